[rtl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// Set-1 scancode key tracker package
// Shared request codes, scancode constants and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  // Request kinds carried on the action field
  typedef enum logic [1:0] {
    ActByte  = 2'd0,
    ActPop   = 2'd1,
    ActQuery = 2'd2,
    ActNone  = 2'd3
  } action_e;

  // Scancode constants
  localparam logic [7:0] PrefixByte = 8'hE0;
  localparam int unsigned BreakBitPos = 7;

  // Ring control from the decoder to the code ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

endpackage

`default_nettype wire

[rtl/skt_code_ring.sv]
// ----------------------------------------------------------------------------
// Code ring
// Wrapping ring of make codes with registered read data. No full check:
// a ring written Depth times without a read reads as empty again.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_code_ring #(
  parameter int unsigned Depth = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  skt_pkg::ring_ctrl_t     ctrl_i,
  input  wire  [15:0]             push_data_i,
  output logic                    empty_o,
  output logic [15:0]             rd_data_o
);
  import skt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  logic [15:0]     mem_q [Depth];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [15:0]     rd_data_q;

  // Pointer advance with wrap at Depth
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    if (ctrl_i.pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (ctrl_i.push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  // Storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
    if (ctrl_i.pop) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign empty_o   = (rd_ptr_q == wr_ptr_q);
  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/scancode_set1_key_tracker.sv]
// ----------------------------------------------------------------------------
// Set-1 scancode key tracker
// Decodes keyboard set-1 bytes into a key state table and a make-code ring.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one request: a received
//   keyboard byte, a pop of the oldest make code, or a key state query.
//   Output channel (out_valid_o / out_ready_i) returns exactly one result per
//   request: scancode_o / scancode_valid_o for pops, key_pressed_o for
//   queries, all zero otherwise.
//   The result of a request is registered and appears on the output register
//   in the cycle after it is accepted. One request per cycle is sustained
//   while the receiver takes each result; the output register is the only
//   stage, and the ring read data is registered in the ring beside it.
//   When the receiver stalls, the result holds and in_ready_o stays low until
//   the result is taken; a request is accepted in the same cycle the held
//   result leaves.
//   Reset clears the prefix flag, all key states, the ring pointers and the
//   output valid. Ring storage is not cleared; the pointers never reach an
//   entry that was not written.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_set1_key_tracker #(
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  action_i,
  input  wire  [7:0]  data_byte_i,
  input  wire  [7:0]  key_index_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [15:0] scancode_o,
  output logic        scancode_valid_o,
  output logic        key_pressed_o
);
  import skt_pkg::*;

  action_e    act;
  logic       in_acc;
  logic       prefix_q, prefix_d;
  logic [255:0] key_table_q;
  logic       key_wr;
  logic       key_val;
  logic [7:0] key_idx;
  logic       is_prefix;
  logic       is_break;
  ring_ctrl_t ring_ctrl;
  logic [15:0] push_data;
  logic       ring_empty;
  logic [15:0] ring_rd_data;
  logic       out_valid_q;
  logic       code_valid_q, code_valid_d;
  logic       pressed_q, pressed_d;

  assign act       = action_e'(action_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;

  // Byte decode
  assign is_prefix = (data_byte_i == PrefixByte);
  assign is_break  = data_byte_i[BreakBitPos];
  assign key_idx   = {prefix_q, data_byte_i[6:0]};
  assign push_data = {prefix_q ? PrefixByte : 8'h00, data_byte_i};

  // Request decode
  always_comb begin
    prefix_d       = prefix_q;
    key_wr         = 1'b0;
    key_val        = 1'b0;
    ring_ctrl.push = 1'b0;
    ring_ctrl.pop  = 1'b0;
    code_valid_d   = 1'b0;
    pressed_d      = 1'b0;
    if (in_acc) begin
      unique case (act)
        ActByte: begin
          if (is_prefix) begin
            prefix_d = 1'b1;
          end else begin
            key_wr         = 1'b1;
            key_val        = !is_break;
            ring_ctrl.push = !is_break;
            prefix_d       = 1'b0;
          end
        end
        ActPop: begin
          ring_ctrl.pop = !ring_empty;
          code_valid_d  = !ring_empty;
        end
        ActQuery: begin
          pressed_d = key_table_q[key_index_i];
        end
        ActNone: begin
          prefix_d = prefix_q;
        end
      endcase
    end
  end

  // Prefix flag and key state table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q    <= 1'b0;
      key_table_q <= '0;
    end else begin
      prefix_q <= prefix_d;
      if (key_wr) begin
        key_table_q[key_idx] <= key_val;
      end
    end
  end

  // Make-code ring
  skt_code_ring #(
    .Depth(FIFO_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ring_ctrl),
    .push_data_i(push_data),
    .empty_o    (ring_empty),
    .rd_data_o  (ring_rd_data)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      code_valid_q <= 1'b0;
      pressed_q    <= 1'b0;
    end else begin
      if (in_acc) begin
        out_valid_q  <= 1'b1;
        code_valid_q <= code_valid_d;
        pressed_q    <= pressed_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign scancode_valid_o = code_valid_q;
  assign scancode_o       = code_valid_q ? ring_rd_data : 16'h0000;
  assign key_pressed_o    = pressed_q;

`ifndef NO_ASSERTIONS
  // Every accepted request produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted request produced no result");

  // A pop from an empty ring returns nothing
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && act == ActPop && ring_empty) |=> (!scancode_valid_o && scancode_o == 16'h0000))
    else $error("pop of empty ring returned a code");

  // Only a query can report a pressed key
  a_pressed_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && act != ActQuery) |=> !key_pressed_o)
    else $error("key_pressed set for a non-query request");

  // Ring never pushed and popped in the same cycle
  a_ring_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_ctrl.push && ring_ctrl.pop))
    else $error("ring push and pop in the same cycle");

  // A break code clears the key it names
  a_break_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_wr && !key_val) |=> !key_table_q[$past(key_idx)])
    else $error("break code left key marked pressed");
`endif

endmodule

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Set-1 scancode key tracker testbench
// Feeds keyboard bytes, pops and key queries through the request channel,
// tracks prefix, key table and make-code ring alongside, and checks every
// result field against the tracked state. Both channels idle at random, the
// receiver stalls long enough to back up the block, and the sender pauses
// until all outstanding results have come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import skt_pkg::*;

  localparam int unsigned RingDepth = 32;
  localparam int unsigned PtrW = $clog2(RingDepth);
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned StallLen = 300;

  // One request on the input channel
  typedef struct {
    action_e    act;
    logic [7:0] data;
    logic [7:0] key;
    bit         hold;  // wait for all results before offering this one
  } key_req_t;

  // One result on the output channel
  typedef struct {
    logic [15:0] code;
    logic        code_vld;
    logic        pressed;
  } key_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  action_e     action;
  logic [7:0]  data_byte;
  logic [7:0]  key_index;
  logic        out_valid_o;
  logic        out_ready;
  logic [15:0] scancode_o;
  logic        scancode_valid_o;
  logic        key_pressed_o;

  scancode_set1_key_tracker #(
    .FIFO_DEPTH(RingDepth)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .action_i        (action),
    .data_byte_i     (data_byte),
    .key_index_i     (key_index),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .scancode_o      (scancode_o),
    .scancode_valid_o(scancode_valid_o),
    .key_pressed_o   (key_pressed_o)
  );

  // Clock and reset
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Tracked block state
  bit              prefix_q;
  bit              key_down [256];
  bit [15:0]       code_ring [RingDepth];
  bit [PtrW-1:0]   rd_ptr;
  bit [PtrW-1:0]   wr_ptr;

  key_req_t        req_q [$];
  key_result_t     result_q [$];
  logic [7:0]      touched_keys [$];
  int              errors;
  int              in_acc;
  int              out_acc;
  int              idle_cycles;
  int              stall_left;
  bit              stall_done;
  key_req_t        cur_req;

  // Apply one accepted request to the tracked state, queue its result
  function automatic void track_request(key_req_t r);
    key_result_t res;
    logic [7:0]  k;
    res = '{code: 16'h0000, code_vld: 1'b0, pressed: 1'b0};
    case (r.act)
      ActByte: begin
        if (r.data == PrefixByte) begin
          prefix_q = 1'b1;
        end else begin
          k = {prefix_q, r.data[6:0]};
          if (r.data[BreakBitPos]) begin
            key_down[k] = 1'b0;
          end else begin
            key_down[k] = 1'b1;
            code_ring[wr_ptr] = prefix_q ? {PrefixByte, r.data} : {8'h00, r.data};
            wr_ptr = wr_ptr + 1'b1;
          end
          prefix_q = 1'b0;
        end
      end
      ActPop: begin
        if (rd_ptr != wr_ptr) begin
          res.code = code_ring[rd_ptr];
          res.code_vld = 1'b1;
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      ActQuery: res.pressed = key_down[r.key];
      default: ;
    endcase
    result_q.push_back(res);
  endfunction

  function automatic void add_req(action_e act, logic [7:0] data, logic [7:0] key,
                                  bit hold = 1'b0);
    req_q.push_back('{act: act, data: data, key: key, hold: hold});
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Press of one key, optionally extended, optionally followed by a query
  function automatic void add_press(bit with_query);
    bit         ext;
    logic [6:0] code;
    ext = ($urandom_range(0, 2) == 0);
    code = 7'($urandom_range(0, 127));
    if (ext) add_req(ActByte, PrefixByte, rnd8());
    add_req(ActByte, {1'b0, code}, rnd8());
    touched_keys.push_back({ext, code});
    if (touched_keys.size() > 40) void'(touched_keys.pop_front());
    if (with_query) add_req(ActQuery, rnd8(), {ext, code});
  endfunction

  function automatic logic [7:0] pick_key();
    if (touched_keys.size() == 0 || $urandom_range(0, 3) == 0) return rnd8();
    return touched_keys[$urandom_range(0, touched_keys.size() - 1)];
  endfunction

  // Release of a recently pressed key or, at times, of a random key
  function automatic void add_release();
    logic [7:0] k;
    k = pick_key();
    if (k[7]) add_req(ActByte, PrefixByte, rnd8());
    add_req(ActByte, {1'b1, k[6:0]}, rnd8());
    if ($urandom_range(0, 1)) add_req(ActQuery, rnd8(), k);
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      action    <= ActByte;
      data_byte <= 8'h00;
      key_index <= 8'h00;
      in_acc    <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        track_request(cur_req);
        in_acc <= in_acc + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (req_q.size() != 0 && !(req_q[0].hold && result_q.size() != 0) &&
            ((in_acc >= 600 && in_acc < 800) || $urandom_range(0, 99) >= 25)) begin
          cur_req = req_q.pop_front();
          in_valid  <= 1'b1;
          action    <= cur_req.act;
          data_byte <= cur_req.data;
          key_index <= cur_req.key;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      out_acc    <= 0;
      stall_left = 0;
      stall_done = 1'b0;
      errors     = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        out_acc <= out_acc + 1;
        if (result_q.size() == 0) begin
          $error("unexpected result: scancode %h valid %b pressed %b",
                 scancode_o, scancode_valid_o, key_pressed_o);
          errors++;
        end else begin
          if (scancode_o !== result_q[0].code) begin
            $error("scancode: expected %h, got %h", result_q[0].code, scancode_o);
            errors++;
          end
          if (scancode_valid_o !== result_q[0].code_vld) begin
            $error("scancode_valid: expected %b, got %b",
                   result_q[0].code_vld, scancode_valid_o);
            errors++;
          end
          if (key_pressed_o !== result_q[0].pressed) begin
            $error("key_pressed: expected %b, got %b", result_q[0].pressed, key_pressed_o);
            errors++;
          end
          void'(result_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!stall_done && out_acc >= 400) begin
        // long hold-off: the block fills and stops taking requests
        stall_done = 1'b1;
        stall_left = StallLen;
        out_ready <= 1'b0;
      end else if (out_acc >= 650 && out_acc < 850) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  // Stimulus
  initial begin
    int r;
    int n;
    int hold_at;
    hold_at = 500;

    // Directed: empty pop, query extremes, unused action, make code zero,
    // repeated prefix, extended make/break, break of key zero
    add_req(ActPop, 8'hFF, 8'hFF);
    add_req(ActQuery, 8'h00, 8'h00);
    add_req(ActQuery, 8'hFF, 8'hFF);
    add_req(ActNone, 8'hFF, 8'hFF);
    add_req(ActNone, 8'h00, 8'h00);
    add_req(ActByte, 8'h00, 8'hFF);
    add_req(ActQuery, 8'hFF, 8'h00);
    add_req(ActPop, 8'h00, 8'h00);
    add_req(ActByte, PrefixByte, 8'h00);
    add_req(ActByte, PrefixByte, 8'h00);
    add_req(ActByte, 8'h48, 8'h00);
    add_req(ActQuery, 8'h00, 8'hC8);
    add_req(ActPop, 8'h00, 8'h00);
    add_req(ActByte, PrefixByte, 8'h00);
    add_req(ActByte, 8'hC8, 8'h00);
    add_req(ActQuery, 8'h00, 8'hC8);
    add_req(ActByte, 8'h7F, 8'h00);
    add_req(ActQuery, 8'h00, 8'h7F);
    add_req(ActByte, 8'hFF, 8'h00);
    add_req(ActQuery, 8'h00, 8'h7F);
    add_req(ActByte, 8'h80, 8'h00);
    add_req(ActQuery, 8'h00, 8'h00);
    add_req(ActPop, 8'h00, 8'h00);
    add_req(ActPop, 8'h00, 8'h00);

    // Random: mostly key presses and releases, with pops, queries and noise
    n = req_q.size();
    add_req(ActPop, rnd8(), rnd8(), 1'b1);
    while (req_q.size() - n < 1030) begin
      r = $urandom_range(0, 99);
      if (req_q.size() - n >= hold_at) begin
        // sender pause until every result is back
        add_req(ActQuery, rnd8(), pick_key(), 1'b1);
        hold_at = 1 << 30;
      end else if (r < 38) begin
        add_press($urandom_range(0, 1));
      end else if (r < 55) begin
        add_release();
      end else if (r < 72) begin
        repeat ($urandom_range(1, 4)) add_req(ActPop, rnd8(), rnd8());
      end else if (r < 82) begin
        add_req(ActQuery, rnd8(), pick_key());
      end else if (r < 94) begin
        // noise: any action, any byte, including stray prefixes
        add_req(action_e'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? PrefixByte : rnd8(), rnd8());
      end else if (r < 97) begin
        // a dangling prefix followed by other requests
        add_req(ActByte, PrefixByte, rnd8());
        add_req(action_e'($urandom_range(1, 3)), rnd8(), rnd8());
        add_press(1'b0);
      end else begin
        // fill the ring to at least its depth so its pointers wrap
        repeat (RingDepth + $urandom_range(0, 8)) add_press(1'b0);
        repeat ($urandom_range(1, 6)) add_req(ActPop, rnd8(), rnd8());
      end
    end

    @(posedge clk_i);
    while (req_q.size() != 0 || in_valid) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (result_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
